// ===== hw/rtl/fqv_pkg.sv =====
// Shared types, constants and helper functions of the FASTQ record validator.
package fqv_pkg;

  localparam int LINE_BYTES = 1024;
  localparam int LINE_W     = $clog2(LINE_BYTES);
  localparam int COUNT_BITS = 40;

  localparam logic [LINE_W-1:0]     LINE_CNT_MAX = LINE_W'(LINE_BYTES - 1);
  localparam logic [COUNT_BITS-1:0] CNT_MAX      = '1;

  // Result queue
  localparam int QDEPTH = 8;
  localparam int QAW    = $clog2(QDEPTH);
  localparam int QCW    = QAW + 1;

  // Characters
  localparam logic [7:0] CH_NL   = 8'h0A;
  localparam logic [7:0] CH_AT   = 8'h40;
  localparam logic [7:0] CH_PLUS = 8'h2B;
  localparam logic [7:0] CH_SEMI = 8'h3B;
  localparam logic [7:0] CH_UB   = 8'h42;
  localparam logic [7:0] CH_LH   = 8'h68;

  // Result kinds
  localparam logic KIND_REC = 1'b0;
  localparam logic KIND_SUM = 1'b1;

  // Register indexes
  localparam logic [1:0] REG_MAX_LINE = 2'd0;
  localparam logic [1:0] REG_MIN_QUAL = 2'd1;
  localparam logic [1:0] REG_MAX_QUAL = 2'd2;

  // Reset values of the registers
  localparam logic [LINE_W-1:0] MAX_LINE_RST = LINE_W'(1022);
  localparam logic [7:0]        MIN_QUAL_RST = 8'd33;
  localparam logic [7:0]        MAX_QUAL_RST = 8'd126;

  typedef enum logic [2:0] {
    ST_OK           = 3'd0,
    ST_BAD_HDR      = 3'd1,
    ST_NO_PLUS      = 3'd2,
    ST_LONG         = 3'd3,
    ST_LEN_MISMATCH = 3'd4,
    ST_BAD_BASE     = 3'd5,
    ST_BAD_QUAL     = 3'd6,
    ST_TRUNC        = 3'd7
  } status_t;

  typedef enum logic [2:0] {
    FMT_NONE      = 3'd0,
    FMT_PHRED33   = 3'd1,
    FMT_PHRED33_M = 3'd2,
    FMT_SOLEXA    = 3'd3,
    FMT_ILL13     = 3'd4,
    FMT_ILL15     = 3'd5
  } fmt_t;

  typedef struct packed {
    logic [LINE_W-1:0] line_cap;
    logic [7:0]        min_q;
    logic [7:0]        max_q;
  } cfg_t;

  typedef struct packed {
    logic                  kind;
    status_t               status;
    logic [LINE_W-1:0]     seq_len;
    logic [7:0]            rec_min;
    logic [7:0]            rec_max;
    logic [COUNT_BITS-1:0] tot_rec;
    logic [COUNT_BITS-1:0] tot_err;
    logic [7:0]            all_min;
    logic [7:0]            all_max;
    fmt_t                  fmt;
    logic                  last;
  } res_t;

  // Up to two results per item; v[1] only with v[0]
  typedef struct packed {
    logic [1:0] v;
    res_t       r0;
    res_t       r1;
  } push_t;

  function automatic logic [2:0] status_rank(input status_t s);
    logic [2:0] r;
    unique case (s)
      ST_TRUNC:        r = 3'd7;
      ST_LONG:         r = 3'd6;
      ST_NO_PLUS:      r = 3'd5;
      ST_LEN_MISMATCH: r = 3'd4;
      ST_BAD_BASE:     r = 3'd3;
      ST_BAD_QUAL:     r = 3'd2;
      ST_BAD_HDR:      r = 3'd1;
      ST_OK:           r = 3'd0;
    endcase
    return r;
  endfunction

  function automatic status_t merge_status(input status_t cur, input status_t add);
    return (status_rank(add) > status_rank(cur)) ? add : cur;
  endfunction

  function automatic logic is_ws(input logic [7:0] b);
    return (b == 8'h20) || (b == 8'h09) || (b == 8'h0B) || (b == 8'h0C) || (b == 8'h0D);
  endfunction

  function automatic logic is_nuc(input logic [7:0] b);
    logic hit;
    unique case (b)
      "A", "T", "C", "G", "N", "a", "t", "c", "g", "n",
      "M", "R", "W", "S", "Y", "K", "m", "r", "w", "s", "y", "k": hit = 1'b1;
      default: hit = 1'b0;
    endcase
    return hit;
  endfunction

  function automatic fmt_t guess_fmt(input logic seen, input logic [7:0] gmin,
                                     input logic [7:0] gmax);
    fmt_t f;
    priority if (!seen)          f = FMT_NONE;
    else if (gmin < CH_SEMI)     f = (gmax >= CH_LH) ? FMT_PHRED33_M : FMT_PHRED33;
    else if (gmin < CH_AT)       f = FMT_SOLEXA;
    else if (gmin < CH_UB)       f = FMT_ILL13;
    else                         f = FMT_ILL15;
    return f;
  endfunction

endpackage

// ===== hw/rtl/fqv_parse.sv =====
// Input register, per-byte record parser state and result generation.
module fqv_parse import fqv_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       take,
  input  logic [7:0] take_byte,
  input  logic       take_eos,
  input  cfg_t       cfg,
  output logic       busy,
  output push_t      push
);

  logic       s0_v_r;
  logic [7:0] s0_byte_r;
  logic       s0_eos_r;

  logic [1:0]            line_idx_r, line_idx_nxt;
  logic                  resync_r, resync_nxt;
  logic                  at_start_r, at_start_nxt;
  logic [LINE_W-1:0]     line_cnt_r, line_cnt_nxt;
  logic [LINE_W-1:0]     pend_ws_r, pend_ws_nxt;
  logic [LINE_W-1:0]     seq_len_r, seq_len_nxt;
  status_t               rec_err_r, rec_err_nxt;
  logic [7:0]            rec_min_r, rec_min_nxt;
  logic [7:0]            rec_max_r, rec_max_nxt;
  logic [7:0]            g_min_r, g_min_nxt;
  logic [7:0]            g_max_r, g_max_nxt;
  logic                  g_seen_r, g_seen_nxt;
  logic [COUNT_BITS-1:0] rec_cnt_r, rec_cnt_nxt;
  logic [COUNT_BITS-1:0] err_cnt_r, err_cnt_nxt;

  logic [LINE_W-1:0] stripped;
  logic              go;
  logic              interior;
  logic              do_emit;
  logic              do_sum;
  status_t           emit_st;
  res_t              rec_res;
  res_t              sum_res;

  assign busy = s0_v_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s0_v_r <= 1'b0;
    end else begin
      s0_v_r <= take;
    end
    if (take) begin
      s0_byte_r <= take_byte;
      s0_eos_r  <= take_eos;
    end
  end

  always_comb begin
    line_idx_nxt = line_idx_r;
    resync_nxt   = resync_r;
    at_start_nxt = at_start_r;
    line_cnt_nxt = line_cnt_r;
    pend_ws_nxt  = pend_ws_r;
    seq_len_nxt  = seq_len_r;
    rec_err_nxt  = rec_err_r;
    rec_min_nxt  = rec_min_r;
    rec_max_nxt  = rec_max_r;
    g_min_nxt    = g_min_r;
    g_max_nxt    = g_max_r;
    g_seen_nxt   = g_seen_r;
    rec_cnt_nxt  = rec_cnt_r;
    err_cnt_nxt  = err_cnt_r;
    stripped     = line_cnt_r - pend_ws_r;
    go           = 1'b0;
    interior     = 1'b0;
    do_emit      = 1'b0;
    do_sum       = 1'b0;
    emit_st      = ST_OK;
    rec_res      = '0;
    sum_res      = '0;
    push         = '0;

    if (s0_v_r) begin
      if (s0_eos_r) begin
        // an open record is closed as truncated before the summary
        if (!resync_r && (line_idx_r != 2'd0 || !at_start_r)) begin
          do_emit = 1'b1;
          emit_st = ST_TRUNC;
        end
        do_sum = 1'b1;
      end else begin
        go = 1'b1;
        if (resync_r) begin
          if (at_start_r && s0_byte_r == CH_AT) begin
            resync_nxt = 1'b0;
          end else begin
            at_start_nxt = (s0_byte_r == CH_NL);
            go           = 1'b0;
          end
        end
        if (go) begin
          if (line_idx_r == 2'd0 && at_start_r && s0_byte_r != CH_AT) begin
            do_emit      = 1'b1;
            emit_st      = ST_BAD_HDR;
            resync_nxt   = 1'b1;
            at_start_nxt = (s0_byte_r == CH_NL);
          end else if (s0_byte_r == CH_NL) begin
            if (line_idx_r == 2'd2 && at_start_r) begin
              rec_err_nxt = merge_status(rec_err_nxt, ST_NO_PLUS);
            end
            at_start_nxt = 1'b1;
            if (line_idx_r == 2'd1) begin
              seq_len_nxt = stripped;
            end
            if (line_idx_r == 2'd3) begin
              if (seq_len_r != '0 && stripped != seq_len_r) begin
                rec_err_nxt = merge_status(rec_err_nxt, ST_LEN_MISMATCH);
              end
              do_emit      = 1'b1;
              emit_st      = rec_err_nxt;
              line_idx_nxt = 2'd0;
            end else begin
              line_idx_nxt = line_idx_r + 2'd1;
              line_cnt_nxt = '0;
              pend_ws_nxt  = '0;
            end
          end else begin
            if (line_idx_r == 2'd2 && at_start_r && s0_byte_r != CH_PLUS) begin
              rec_err_nxt = merge_status(rec_err_nxt, ST_NO_PLUS);
            end
            at_start_nxt = 1'b0;
            if (line_cnt_r < LINE_CNT_MAX) begin
              line_cnt_nxt = line_cnt_r + LINE_W'(1);
            end
            if (line_cnt_nxt > cfg.line_cap) begin
              rec_err_nxt = merge_status(rec_err_nxt, ST_LONG);
            end
            if (is_ws(s0_byte_r)) begin
              if (pend_ws_r < line_cnt_nxt) begin
                pend_ws_nxt = pend_ws_r + LINE_W'(1);
              end
            end else begin
              interior    = (pend_ws_r != '0);
              pend_ws_nxt = '0;
              if (line_idx_r == 2'd1) begin
                if (interior || !is_nuc(s0_byte_r)) begin
                  rec_err_nxt = merge_status(rec_err_nxt, ST_BAD_BASE);
                end
              end else if (line_idx_r == 2'd3 && seq_len_r != '0) begin
                if (s0_byte_r < rec_min_r) rec_min_nxt = s0_byte_r;
                if (s0_byte_r > rec_max_r) rec_max_nxt = s0_byte_r;
                if (interior || s0_byte_r < cfg.min_q || s0_byte_r > cfg.max_q) begin
                  rec_err_nxt = merge_status(rec_err_nxt, ST_BAD_QUAL);
                end
              end
            end
          end
        end
      end
    end

    // Close the record: counts, global extremes, then clear per-record state
    if (do_emit) begin
      if (rec_cnt_r != CNT_MAX) rec_cnt_nxt = rec_cnt_r + COUNT_BITS'(1);
      if (emit_st != ST_OK && err_cnt_r != CNT_MAX) begin
        err_cnt_nxt = err_cnt_r + COUNT_BITS'(1);
      end
      // an empty sequence leaves the extremes alone
      if (emit_st == ST_OK && seq_len_r != '0) begin
        if (rec_min_r < g_min_r) g_min_nxt = rec_min_r;
        if (rec_max_r > g_max_r) g_max_nxt = rec_max_r;
        g_seen_nxt = 1'b1;
      end
      rec_res.kind    = KIND_REC;
      rec_res.status  = emit_st;
      rec_res.seq_len = seq_len_r;
      rec_res.rec_min = rec_min_r;
      rec_res.rec_max = rec_max_r;
      rec_res.tot_rec = rec_cnt_nxt;
      rec_res.tot_err = err_cnt_nxt;
      rec_res.all_min = g_min_nxt;
      rec_res.all_max = g_max_nxt;
      rec_res.fmt     = guess_fmt(g_seen_nxt, g_min_nxt, g_max_nxt);
      rec_res.last    = !do_sum;
      push.v[0]       = 1'b1;
      push.r0         = rec_res;
      seq_len_nxt     = '0;
      rec_err_nxt     = ST_OK;
      rec_min_nxt     = 8'hFF;
      rec_max_nxt     = 8'h00;
      line_cnt_nxt    = '0;
      pend_ws_nxt     = '0;
    end

    if (do_sum) begin
      sum_res.kind    = KIND_SUM;
      sum_res.status  = ST_OK;
      sum_res.tot_rec = rec_cnt_nxt;
      sum_res.tot_err = err_cnt_nxt;
      sum_res.all_min = g_min_nxt;
      sum_res.all_max = g_max_nxt;
      sum_res.fmt     = guess_fmt(g_seen_nxt, g_min_nxt, g_max_nxt);
      sum_res.last    = 1'b1;
      if (do_emit) begin
        push.v[1] = 1'b1;
        push.r1   = sum_res;
      end else begin
        push.v[0] = 1'b1;
        push.r0   = sum_res;
      end
      line_idx_nxt = 2'd0;
      resync_nxt   = 1'b0;
      at_start_nxt = 1'b1;
      line_cnt_nxt = '0;
      pend_ws_nxt  = '0;
      seq_len_nxt  = '0;
      rec_err_nxt  = ST_OK;
      rec_min_nxt  = 8'hFF;
      rec_max_nxt  = 8'h00;
      g_min_nxt    = 8'hFF;
      g_max_nxt    = 8'h00;
      g_seen_nxt   = 1'b0;
      rec_cnt_nxt  = '0;
      err_cnt_nxt  = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      line_idx_r <= 2'd0;
      resync_r   <= 1'b0;
      at_start_r <= 1'b1;
      line_cnt_r <= '0;
      pend_ws_r  <= '0;
      seq_len_r  <= '0;
      rec_err_r  <= ST_OK;
      rec_min_r  <= 8'hFF;
      rec_max_r  <= 8'h00;
      g_min_r    <= 8'hFF;
      g_max_r    <= 8'h00;
      g_seen_r   <= 1'b0;
      rec_cnt_r  <= '0;
      err_cnt_r  <= '0;
    end else begin
      line_idx_r <= line_idx_nxt;
      resync_r   <= resync_nxt;
      at_start_r <= at_start_nxt;
      line_cnt_r <= line_cnt_nxt;
      pend_ws_r  <= pend_ws_nxt;
      seq_len_r  <= seq_len_nxt;
      rec_err_r  <= rec_err_nxt;
      rec_min_r  <= rec_min_nxt;
      rec_max_r  <= rec_max_nxt;
      g_min_r    <= g_min_nxt;
      g_max_r    <= g_max_nxt;
      g_seen_r   <= g_seen_nxt;
      rec_cnt_r  <= rec_cnt_nxt;
      err_cnt_r  <= err_cnt_nxt;
    end
  end

  // resync only ever runs while waiting for a header
  a_resync_hdr: assert property (@(posedge clk) disable iff (!rst_n)
    resync_r |-> (line_idx_r == 2'd0))
    else $error("resync outside header line");

  a_ws_run: assert property (@(posedge clk) disable iff (!rst_n)
    pend_ws_r <= line_cnt_r)
    else $error("trailing whitespace run longer than line");

  // a second result is always the summary and closes the item
  a_two_res: assert property (@(posedge clk) disable iff (!rst_n)
    push.v[1] |-> (push.v[0] && push.r1.kind == KIND_SUM && push.r1.last && !push.r0.last))
    else $error("bad double result");

endmodule

// ===== hw/rtl/fqv_outq.sv =====
// Result queue between the parser and the output channel.
module fqv_outq import fqv_pkg::*; (
  input  logic  clk,
  input  logic  rst_n,
  input  push_t push,
  input  logic  busy,
  output logic  in_hold,
  output logic  q_valid,
  input  logic  q_stall,
  output res_t  q_head
);

  localparam int QSW = QCW + 1;

  res_t             q_mem [QDEPTH];
  logic [QAW-1:0]   wr_ptr_r, wr_ptr_nxt;
  logic [QAW-1:0]   rd_ptr_r, rd_ptr_nxt;
  logic [QCW-1:0]   q_cnt_r, q_cnt_nxt;
  logic [1:0]       n_push;
  logic             pop;
  logic [QSW-1:0]   hold_lvl;

  assign q_valid = (q_cnt_r != '0);
  assign q_head  = q_mem[rd_ptr_r];
  assign pop     = q_valid && !q_stall;
  assign n_push  = {1'b0, push.v[0]} + {1'b0, push.v[1]};

  // the item in the parser may still add two results
  assign hold_lvl = QSW'(q_cnt_r) + (busy ? QSW'(2) : QSW'(0));
  assign in_hold  = hold_lvl > QSW'(QDEPTH - 2);

  assign wr_ptr_nxt = wr_ptr_r + QAW'(n_push);
  assign rd_ptr_nxt = rd_ptr_r + QAW'(pop);
  assign q_cnt_nxt  = q_cnt_r + QCW'(n_push) - QCW'(pop);

  always_ff @(posedge clk) begin
    if (push.v[0]) q_mem[wr_ptr_r] <= push.r0;
    if (push.v[1]) q_mem[wr_ptr_r + QAW'(1)] <= push.r1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      q_cnt_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      q_cnt_r  <= q_cnt_nxt;
    end
  end

  a_no_ovf: assert property (@(posedge clk) disable iff (!rst_n)
    q_cnt_r <= QCW'(QDEPTH))
    else $error("result queue overflow");

  a_hold_keeps: assert property (@(posedge clk) disable iff (!rst_n)
    (q_valid && q_stall) |=> (q_cnt_r >= $past(q_cnt_r)))
    else $error("queue lost a result while stalled");

endmodule

// ===== hw/rtl/fastq_record_validator.sv =====
// FASTQ record validator top level: register port, parser and result queue.
// A result passes the input register and then the result queue before out_valid offers it.
// Unstalled, one byte per cycle; end of stream yields up to two results, one per cycle.
// in_stall rises only when the 8-entry result queue could not absorb two more results.
// Reset (rst_n, synchronous, active low) clears parser state, counts, the queue and
// returns the three registers to 1022, 33 and 126.
module fastq_record_validator import fqv_pkg::*; (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic [3:0]            paddr,
  input  logic [31:0]           pwdata,
  output logic [31:0]           prdata,
  output logic                  pready,
  input  logic                  in_valid,
  output logic                  in_stall,
  input  logic [7:0]            in_data_byte,
  input  logic                  in_end_of_stream,
  output logic                  out_valid,
  input  logic                  out_stall,
  output logic                  out_result_kind,
  output logic [2:0]            out_record_status,
  output logic [LINE_W-1:0]     out_seq_length,
  output logic [7:0]            out_rec_min_qual,
  output logic [7:0]            out_rec_max_qual,
  output logic [COUNT_BITS-1:0] out_total_records,
  output logic [COUNT_BITS-1:0] out_total_errors,
  output logic [7:0]            out_all_min_qual,
  output logic [7:0]            out_all_max_qual,
  output logic [2:0]            out_format_guess,
  output logic                  out_last_result
);

  logic [LINE_W-1:0] max_line_r;
  logic [7:0]        min_qual_r;
  logic [7:0]        max_qual_r;
  logic [1:0]        reg_idx;
  logic              wr_en;
  cfg_t              cfg;
  push_t             push;
  logic              busy;
  logic              take;
  res_t              head;

  assign pready  = 1'b1;
  assign reg_idx = paddr[3:2];
  assign wr_en   = psel && penable && pwrite;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      max_line_r <= MAX_LINE_RST;
      min_qual_r <= MIN_QUAL_RST;
      max_qual_r <= MAX_QUAL_RST;
    end else if (wr_en) begin
      unique case (reg_idx)
        REG_MAX_LINE: max_line_r <= pwdata[LINE_W-1:0];
        REG_MIN_QUAL: min_qual_r <= pwdata[7:0];
        REG_MAX_QUAL: max_qual_r <= pwdata[7:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (reg_idx)
      REG_MAX_LINE: prdata = 32'(max_line_r);
      REG_MIN_QUAL: prdata = 32'(min_qual_r);
      REG_MAX_QUAL: prdata = 32'(max_qual_r);
      default:      prdata = '0;
    endcase
  end

  assign cfg.line_cap = max_line_r;
  assign cfg.min_q    = min_qual_r;
  assign cfg.max_q    = max_qual_r;

  assign take = in_valid && !in_stall;

  fqv_parse u_parse (
    .clk       (clk),
    .rst_n     (rst_n),
    .take      (take),
    .take_byte (in_data_byte),
    .take_eos  (in_end_of_stream),
    .cfg       (cfg),
    .busy      (busy),
    .push      (push)
  );

  fqv_outq u_outq (
    .clk     (clk),
    .rst_n   (rst_n),
    .push    (push),
    .busy    (busy),
    .in_hold (in_stall),
    .q_valid (out_valid),
    .q_stall (out_stall),
    .q_head  (head)
  );

  assign out_result_kind   = head.kind;
  assign out_record_status = head.status;
  assign out_seq_length    = head.seq_len;
  assign out_rec_min_qual  = head.rec_min;
  assign out_rec_max_qual  = head.rec_max;
  assign out_total_records = head.tot_rec;
  assign out_total_errors  = head.tot_err;
  assign out_all_min_qual  = head.all_min;
  assign out_all_max_qual  = head.all_max;
  assign out_format_guess  = head.fmt;
  assign out_last_result   = head.last;

endmodule
